FILE: rtl/core/hbs_pkg.sv
// Shared types and constants of the heightmap barycentric sampler.
// No dependencies; the top level and the port checker import this package.
`default_nettype none

package hbs_pkg;

	localparam int GRID_SIZE_DEF = 256;

	localparam int POS_W    = 20;  // Q11.8 world positions
	localparam int SAMPLE_W = 16;  // Q1.14 height samples
	localparam int HEIGHT_W = 18;  // Q9.8 result
	localparam int CL_W     = 16;  // Q8.8 cell length and gain
	localparam int FRAC_W   = 8;   // Q0.8 in-cell fraction
	localparam int QUO_W    = POS_W + FRAC_W;  // cell index and fraction together
	localparam int CFG_IW   = 8;

	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 18'sd131071;
	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = -18'sd131072;

	localparam logic [CL_W-1:0] CELL_LENGTH_RST  = 16'd771;
	localparam logic [CL_W-1:0] HEIGHT_SCALE_RST = 16'd17920;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ORIGIN_X     = 8'd0,
		CFG_ORIGIN_Z     = 8'd1,
		CFG_CELL_LENGTH  = 8'd2,
		CFG_HEIGHT_SCALE = 8'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef struct packed {
		logic                       opcode;
		logic [7:0]                 grid_x_index;
		logic [7:0]                 grid_z_index;
		logic signed [SAMPLE_W-1:0] sample_value;
		logic signed [POS_W-1:0]    pos_x;
		logic signed [POS_W-1:0]    pos_z;
	} req_t;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] height;
		logic                       on_terrain;
	} rsp_t;

	// item details carried alongside the divider
	typedef struct packed {
		logic                       op;
		logic                       neg_x;
		logic                       neg_z;
		logic [7:0]                 gx;
		logic [7:0]                 gz;
		logic signed [SAMPLE_W-1:0] sample;
	} side_t;

endpackage

`default_nettype wire

FILE: rtl/core/hbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/hbs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the top level sizes it from hbs_pkg constants.
`default_nettype none

module hbs_div #(
	parameter int NW = 28,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output      logic [NW-1:0] quo
);

	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [NW-1:0] quo_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW-1:0] rem_i;
		logic [NW-1:0] num_i;
		logic [NW-1:0] quo_i;
		logic [DW:0]   trial;
		logic          fits;

		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign num_i = num;
			assign quo_i = '0;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign num_i = num_s[k-1];
			assign quo_i = quo_s[k-1];
		end

		// bring down the next dividend bit and try the subtraction
		assign trial = {rem_i, num_i[NW-1]};
		assign fits  = trial >= {1'b0, den};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
				num_s[k] <= {num_i[NW-2:0], 1'b0};
				quo_s[k] <= {quo_i[NW-2:0], fits};
			end
		end
	end

	assign quo = quo_s[NW-1];

endmodule

`default_nettype wire

FILE: rtl/core/heightmap_barycentric_sampler.sv
// Heightmap sampler: one request beat per cycle sustained unless a stalled response
// beat holds the pipe; the 28-stage quotient pipeline sets the depth.
// Write beats give no response beat; they update the store in request order.
// Reset (arst_n low, asynchronous) empties the pipeline and restores the
// register defaults; the height store is not cleared and is undefined until written.
`default_nettype none

module heightmap_barycentric_sampler #(
	parameter int GRID_SIZE = hbs_pkg::GRID_SIZE_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output      logic                       req_ready,
	input  wire hbs_pkg::req_t              req,
	output      logic                       rsp_valid,
	input  wire logic                       rsp_ready,
	output      hbs_pkg::rsp_t              rsp,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [hbs_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [hbs_pkg::POS_W-1:0]  cfg_data
);

	import hbs_pkg::*;

	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = (GRID_SIZE > 2) ? $clog2(GRID_SIZE) : 1;
	localparam int NW    = QUO_W;
	localparam int PW    = SAMPLE_W + 10;  // corner product
	localparam int BW    = PW + 1;         // blend, Q.22
	localparam int SW    = BW + CL_W + 1;  // scaled blend, Q.30

	// ---------------- configuration registers ----------------
	logic signed [POS_W-1:0] origin_x_q, origin_z_q;
	logic [CL_W-1:0]         cell_length_q, height_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_z_q     <= '0;
			cell_length_q  <= CELL_LENGTH_RST;
			height_scale_q <= HEIGHT_SCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ORIGIN_X:     origin_x_q     <= cfg_data;
				CFG_ORIGIN_Z:     origin_z_q     <= cfg_data;
				CFG_CELL_LENGTH:  cell_length_q  <= cfg_data[CL_W-1:0];
				CFG_HEIGHT_SCALE: height_scale_q <= cfg_data[CL_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// ---------------- flow control ----------------
	// One advance for the whole pipe: every stage moves when the output
	// register is empty or its beat is being taken.
	logic adv;
	assign adv       = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	// ---------------- stage 1: offset from origin ----------------
	logic signed [POS_W:0] tx, tz;
	assign tx = {req.pos_x[POS_W-1], req.pos_x} - {origin_x_q[POS_W-1], origin_x_q};
	assign tz = {req.pos_z[POS_W-1], req.pos_z} - {origin_z_q[POS_W-1], origin_z_q};

	logic          vld_s1;
	side_t         side_s1;
	logic [NW-1:0] numx_s1, numz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.op     <= req.opcode;
			side_s1.neg_x  <= tx[POS_W];
			side_s1.neg_z  <= tz[POS_W];
			side_s1.gx     <= req.grid_x_index;
			side_s1.gz     <= req.grid_z_index;
			side_s1.sample <= req.sample_value;
			// scale by 256 so the quotient holds cell index and Q0.8 fraction
			numx_s1 <= {tx[POS_W-1:0], FRAC_W'(0)};
			numz_s1 <= {tz[POS_W-1:0], FRAC_W'(0)};
		end
	end

	// ---------------- quotient pipeline ----------------
	logic [NW-1:0] qx, qz;

	hbs_div #(.NW(NW), .DW(CL_W)) u_div_x (
		.clk(clk), .en(adv), .num(numx_s1), .den(cell_length_q), .quo(qx)
	);
	hbs_div #(.NW(NW), .DW(CL_W)) u_div_z (
		.clk(clk), .en(adv), .num(numz_s1), .den(cell_length_q), .quo(qz)
	);

	// carry valid and item details alongside, same depth as the divider
	logic  vld_d_s [NW];
	side_t side_d_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d_s[k] <= 1'b0;
			end else if (adv) begin
				vld_d_s[k] <= (k == 0) ? vld_s1 : vld_d_s[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				side_d_s[k] <= (k == 0) ? side_s1 : side_d_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	logic  vld_dq;
	side_t side_dq;
	assign vld_dq  = vld_d_s[NW-1];
	assign side_dq = side_d_s[NW-1];

	// ---------------- stage 2: grid check and addresses ----------------
	logic [POS_W-1:0]  cx, cz;
	logic [FRAC_W-1:0] fu, fv;
	logic              on_c, we_c;
	logic [AW-1:0]     base_c;

	assign cx = qx[NW-1:FRAC_W];
	assign cz = qz[NW-1:FRAC_W];
	assign fu = qx[FRAC_W-1:0];
	assign fv = qz[FRAC_W-1:0];

	assign on_c = side_dq.op == OP_QUERY && !side_dq.neg_x && !side_dq.neg_z
	           && cell_length_q != '0
	           && cx < POS_W'(GRID_SIZE - 1) && cz < POS_W'(GRID_SIZE - 1);
	assign base_c = AW'(32'(cx[XW-1:0]) * GRID_SIZE + 32'(cz[XW-1:0]));
	assign we_c = side_dq.op == OP_WRITE
	           && 32'(side_dq.gx) < GRID_SIZE && 32'(side_dq.gz) < GRID_SIZE;

	logic                       vld_s2, op_s2, on_s2, we_s2;
	logic [FRAC_W-1:0]          u_s2, v_s2;
	logic [AW-1:0]              a00_s2, a10_s2, a01_s2, a11_s2, waddr_s2;
	logic signed [SAMPLE_W-1:0] wdata_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_dq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2    <= side_dq.op;
			on_s2    <= on_c;
			we_s2    <= we_c;
			u_s2     <= fu;
			v_s2     <= fv;
			a00_s2   <= base_c;
			a10_s2   <= AW'(32'(base_c) + GRID_SIZE);
			a01_s2   <= AW'(32'(base_c) + 1);
			a11_s2   <= AW'(32'(base_c) + GRID_SIZE + 1);
			waddr_s2 <= AW'(32'(side_dq.gx) * GRID_SIZE + 32'(side_dq.gz));
			wdata_s2 <= side_dq.sample;
		end
	end

	// ---------------- stage 3: corner reads ----------------
	// Four copies of the store, one per corner; writes land in all of them at
	// the same pipe position as the reads, so request order is kept.
	logic                ram_we, ram_re;
	logic [SAMPLE_W-1:0] h00, h10, h01, h11;

	assign ram_we = adv && vld_s2 && we_s2;
	assign ram_re = adv && vld_s2 && on_s2;

	hbs_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram00 (
		.clk(clk), .we(ram_we), .waddr(waddr_s2), .wdata(wdata_s2),
		.re(ram_re), .raddr(a00_s2), .rdata(h00)
	);
	hbs_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram10 (
		.clk(clk), .we(ram_we), .waddr(waddr_s2), .wdata(wdata_s2),
		.re(ram_re), .raddr(a10_s2), .rdata(h10)
	);
	hbs_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram01 (
		.clk(clk), .we(ram_we), .waddr(waddr_s2), .wdata(wdata_s2),
		.re(ram_re), .raddr(a01_s2), .rdata(h01)
	);
	hbs_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram11 (
		.clk(clk), .we(ram_we), .waddr(waddr_s2), .wdata(wdata_s2),
		.re(ram_re), .raddr(a11_s2), .rdata(h11)
	);

	logic              vld_s3, op_s3, on_s3;
	logic [FRAC_W-1:0] u_s3, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3 <= op_s2;
			on_s3 <= on_s2;
			u_s3  <= u_s2;
			v_s3  <= v_s2;
		end
	end

	// ---------------- stage 4: triangle weights and products ----------------
	// Upper triangle when u + v <= 1: h00, h10, h01 weighted 1-u-v, u, v.
	// Lower triangle otherwise: h11, h10, h01 weighted u+v-1, 1-v, 1-u.
	logic [FRAC_W:0]            uv, wa, wb, wc;
	logic                       upper;
	logic signed [SAMPLE_W-1:0] ha;

	assign uv    = {1'b0, u_s3} + {1'b0, v_s3};
	assign upper = uv <= 9'd256;
	assign ha    = upper ? $signed(h00) : $signed(h11);
	assign wa    = upper ? 9'(9'd256 - uv) : 9'(uv - 9'd256);
	assign wb    = upper ? {1'b0, u_s3} : 9'(9'd256 - {1'b0, v_s3});
	assign wc    = upper ? {1'b0, v_s3} : 9'(9'd256 - {1'b0, u_s3});

	logic                 vld_s4, op_s4, on_s4;
	logic signed [PW-1:0] pa_s4, pb_s4, pc_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s4 <= op_s3;
			on_s4 <= on_s3;
			pa_s4 <= PW'(ha) * PW'($signed({1'b0, wa}));
			pb_s4 <= PW'($signed(h10)) * PW'($signed({1'b0, wb}));
			pc_s4 <= PW'($signed(h01)) * PW'($signed({1'b0, wc}));
		end
	end

	// ---------------- stage 5: blend ----------------
	logic                 vld_s5, op_s5, on_s5;
	logic signed [BW-1:0] blend_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s5    <= op_s4;
			on_s5    <= on_s4;
			blend_s5 <= BW'(pa_s4) + BW'(pb_s4) + BW'(pc_s4);
		end
	end

	// ---------------- stage 6: apply gain ----------------
	logic                 vld_s6, op_s6, on_s6;
	logic signed [SW-1:0] scaled_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s6     <= op_s5;
			on_s6     <= on_s5;
			scaled_s6 <= SW'(blend_s5) * SW'($signed({1'b0, height_scale_q}));
		end
	end

	// ---------------- stage 7: floor, saturate, output register ----------------
	// Dropping the low 22 bits of the signed product floors Q.30 down to Q9.8.
	logic signed [SW-23:0]      hq;
	logic signed [HEIGHT_W-1:0] hsat;

	assign hq = scaled_s6[SW-1:22];

	always_comb begin
		if (!on_s6) begin
			hsat = '0;
		end else if (hq > (SW-22)'(HEIGHT_MAX)) begin
			hsat = HEIGHT_MAX;
		end else if (hq < (SW-22)'(HEIGHT_MIN)) begin
			hsat = HEIGHT_MIN;
		end else begin
			hsat = hq[HEIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			// drop write items here: they carry no response beat
			rsp_valid <= vld_s6 && op_s6 == OP_QUERY;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.height     <= hsat;
			rsp.on_terrain <= on_s6;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/hbs_checker.sv
// Port-level checks on the heightmap sampler, bound to the top level.
// Depends on hbs_pkg and heightmap_barycentric_sampler.
`default_nettype none

module hbs_port_checks (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire hbs_pkg::rsp_t              rsp,
	input wire logic                       cfg_ready
);

	import hbs_pkg::*;

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// off the grid the height is zero
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.on_terrain |-> rsp.height == '0)
		else $error("off-terrain response with nonzero height");

	// with the output register empty the pipe always takes a request
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request refused while output register empty");

	// a taken response frees the output for the next request
	a_ready_after: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |-> req_ready && cfg_ready)
		else $error("pipe stalled although response beat was taken");

endmodule

bind heightmap_barycentric_sampler hbs_port_checks u_port_checks (
	.clk(clk), .arst_n(arst_n), .req_ready(req_ready),
	.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp), .cfg_ready(cfg_ready)
);

`default_nettype wire
